// ----- design/fac_pkg.sv -----
// Package for the frustum box culling block: widths, plane table and types.
// Depends on nothing; imported by frustum_aabb_cull.
package fac_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 32;
  localparam int COEF_W     = DATA_WIDTH + 1;
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int D_SHIFT    = 16;

  localparam logic [1:0] PLANE_ROW [NUM_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic       PLANE_SUB [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_BOX  = 1'b1
  } func_t;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

endpackage

// ----- design/frustum_aabb_cull.sv -----
// Frustum culling of axis-aligned boxes against a stored 4x4 matrix.
// Depends on fac_pkg.
//
// Channel  Dir  Contents
// s_*      in   tuser: func; tdata: elem_index, elem_value, box min x/y/z, box max x/y/z
// m_*      out  tdata: visible (one result per box request, none per load)
//
// One request per cycle while m_tready does not stall; a box result passes the coef, prod, pa/pb and m_tdata registers.
// Stages: coefficient sums, eighteen 33x32 multiplies, pair sums, final sum and sign.
// Loads write the matrix at acceptance, so each box sees every earlier load.
// Reset clears the matrix and all valid bits. A stall on m_tready holds all stages.
module frustum_aabb_cull
  import fac_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // elem_index[3:0], elem_value[35:4], box_min_x[67:36], box_min_y[99:68],
  // box_min_z[131:100], box_max_x[163:132], box_max_y[195:164], box_max_z[227:196]
  input  logic [231:0] s_tdata,
  // func[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // visible[0]
  output logic [7:0]   m_tdata
);

  logic signed [DATA_WIDTH-1:0] mtx [16];
  logic        en;
  logic        acc;
  logic [3:0]  elem_index;
  coord_t      elem_value;
  coord_t      bmin [3];
  coord_t      bmax [3];

  coef_t       coef_next [NUM_PLANES][4];
  coef_t       coef      [NUM_PLANES][4];
  coord_t      lo1 [3];
  coord_t      hi1 [3];
  logic [2:0]  hge1;
  logic        v1;

  prod_t       prod_next [NUM_PLANES][3];
  prod_t       prod      [NUM_PLANES][3];
  coef_t       dterm     [NUM_PLANES];
  logic        v2;

  sum_t        pa_next [NUM_PLANES];
  sum_t        pb_next [NUM_PLANES];
  sum_t        pa      [NUM_PLANES];
  sum_t        pb      [NUM_PLANES];
  logic        v3;

  logic [NUM_PLANES-1:0] neg;
  logic        visible;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && s_tready;

  assign elem_index = s_tdata[3:0];
  assign elem_value = s_tdata[35:4];
  assign bmin[0]    = s_tdata[67:36];
  assign bmin[1]    = s_tdata[99:68];
  assign bmin[2]    = s_tdata[131:100];
  assign bmax[0]    = s_tdata[163:132];
  assign bmax[1]    = s_tdata[195:164];
  assign bmax[2]    = s_tdata[227:196];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 4; k++) begin
        if (PLANE_SUB[p])
          coef_next[p][k] = COEF_W'(mtx[k*4+3]) - COEF_W'(mtx[k*4+int'(PLANE_ROW[p])]);
        else
          coef_next[p][k] = COEF_W'(mtx[k*4+3]) + COEF_W'(mtx[k*4+int'(PLANE_ROW[p])]);
      end
    end
  end

  // pick the corner that maximises each term
  always_comb begin
    prod_t  m;
    coord_t x;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 3; k++) begin
        x = (hge1[k] ^ coef[p][k][COEF_W-1]) ? hi1[k] : lo1[k];
        m = coef[p][k] * x;
        prod_next[p][k] = m;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      pa_next[p] = SUM_W'(prod[p][0]) + SUM_W'(prod[p][1]);
      pb_next[p] = SUM_W'(prod[p][2]) + (SUM_W'(dterm[p]) <<< D_SHIFT);
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      neg[p] = sum_t'(pa[p] + pb[p]) < 0;
    end
    visible = !(|neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) mtx[i] <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (acc && func_t'(s_tuser[0]) == FUNC_LOAD)
        mtx[elem_index] <= DATA_WIDTH'(elem_value);
      if (en) begin
        v1       <= acc && func_t'(s_tuser[0]) == FUNC_BOX;
        v2       <= v1;
        v3       <= v2;
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef <= coef_next;
      for (int k = 0; k < 3; k++) begin
        lo1[k]  <= bmin[k];
        hi1[k]  <= bmax[k];
        hge1[k] <= bmax[k] >= bmin[k];
      end
      prod <= prod_next;
      for (int p = 0; p < NUM_PLANES; p++) dterm[p] <= coef[p][3];
      pa <= pa_next;
      pb <= pb_next;
      m_tdata <= {7'd0, visible};
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for frustum_aabb_cull: directed and random matrix loads and box tests.
// Predicts visibility with its own exact wide-integer plane evaluation; depends on fac_pkg.
`timescale 1ns / 100ps

module tb;
  import fac_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [231:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  frustum_aabb_cull u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [DATA_WIDTH-1:0] mvp [16];
  logic                         visible_q [$];
  int  errors = 0;
  int  boxes_sent = 0;
  int  culled_seen = 0;
  int  idle_left = 0;
  bit  calm = 1'b0;

  function automatic logic predict_visible(coord_t lo [3], coord_t hi [3]);
    logic signed [127:0] co [4];
    logic signed [127:0] acc;
    logic signed [127:0] x, y, z;
    logic all_out;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 4; k++) begin
        if (PLANE_SUB[p])
          co[k] = 128'(mvp[k*4+3]) - 128'(mvp[k*4+PLANE_ROW[p]]);
        else
          co[k] = 128'(mvp[k*4+3]) + 128'(mvp[k*4+PLANE_ROW[p]]);
      end
      all_out = 1'b1;
      for (int c = 0; c < 8; c++) begin
        x = (c & 4) ? 128'(hi[0]) : 128'(lo[0]);
        y = (c & 2) ? 128'(hi[1]) : 128'(lo[1]);
        z = (c & 1) ? 128'(hi[2]) : 128'(lo[2]);
        acc = co[0]*x + co[1]*y + co[2]*z + (co[3] <<< D_SHIFT);
        if (acc >= 0) all_out = 1'b0;
      end
      if (all_out) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_request(func_t f, logic [3:0] idx, logic [31:0] val,
                              coord_t lo [3], coord_t hi [3]);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {4'b0, hi[2], hi[1], hi[0], lo[2], lo[1], lo[0], val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (f == FUNC_LOAD) begin
      mvp[idx] = val;
    end else begin
      visible_q.push_back(predict_visible(lo, hi));
      boxes_sent++;
    end
  endtask

  task automatic load_elem(int idx, logic [31:0] val);
    coord_t z3 [3];
    z3 = '{default: '0};
    send_request(FUNC_LOAD, idx[3:0], val, z3, z3);
  endtask

  task automatic test_box(coord_t lo [3], coord_t hi [3]);
    send_request(FUNC_BOX, 4'($urandom), $urandom, lo, hi);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h8000_0000);
      1: return coord_t'(32'h7FFF_FFFF);
      2: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      3: return 32'h0;
      default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (visible_q.size() == 0) begin
          $display("%0t: result with none expected, actual %0d", $time, m_tdata[0]);
          errors++;
        end else begin
          if (visible_q[0] !== m_tdata[0]) begin
            $display("%0t: visible mismatch, expected %0d actual %0d",
                     $time, visible_q[0], m_tdata[0]);
            errors++;
          end
          if (!visible_q[0]) culled_seen++;
          void'(visible_q.pop_front());
        end
      end
      if (calm) begin
        idle_left = 0;
        m_tready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic drain();
    s_tvalid <= 1'b0;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_after_reset();
    coord_t lo [3], hi [3];
    lo = '{coord_t'(32'h8000_0000), coord_t'(32'h8000_0000), coord_t'(32'h8000_0000)};
    hi = '{coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF), coord_t'(32'h7FFF_FFFF)};
    test_box(lo, hi);
    test_box(hi, lo);
  endtask

  task automatic test_identity();
    coord_t lo [3], hi [3];
    for (int i = 0; i < 16; i++)
      load_elem(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
    lo = '{32'sh0002_0000, 32'sh0, 32'sh0};
    hi = '{32'sh0003_0000, 32'sh0, 32'sh0};
    test_box(lo, hi);
    lo = '{-32'sh0000_8000, -32'sh0000_8000, -32'sh0000_8000};
    hi = '{32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000};
    test_box(lo, hi);
    test_box(hi, lo);
    lo = '{32'sh0, 32'sh0, -32'sh0005_0000};
    hi = '{32'sh0, 32'sh0, -32'sh0004_0000};
    test_box(lo, hi);
    lo = '{32'sh0001_0000, 32'sh0, 32'sh0};
    test_box(lo, lo);
  endtask

  task automatic test_extremes();
    coord_t lo [3], hi [3];
    for (int i = 0; i < 16; i++)
      load_elem(i, (i & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    lo = '{default: coord_t'(32'h8000_0000)};
    hi = '{default: coord_t'(32'h7FFF_FFFF)};
    test_box(lo, hi);
    test_box(lo, lo);
    test_box(hi, hi);
    drain();
  endtask

  task automatic test_random(int n);
    coord_t lo [3], hi [3];
    coord_t t;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if (i > n - 150) calm = 1'b1;
      if ($urandom_range(0, 9) < 3) begin
        load_elem($urandom_range(0, 15), rand_elem());
      end else begin
        for (int k = 0; k < 3; k++) begin
          lo[k] = rand_coord();
          hi[k] = rand_coord();
          if ($urandom_range(0, 7) != 0 && lo[k] > hi[k]) begin
            t = lo[k]; lo[k] = hi[k]; hi[k] = t;
          end
        end
        test_box(lo, hi);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) mvp[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_identity();
    test_extremes();
    test_random(1750);
    drain();
    $display("Sent %0d box requests (%0d culled) with random loads, stalls and gaps.",
             boxes_sent, culled_seen);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fac_pkg.sv
design/frustum_aabb_cull.sv
tb/tb.sv
